### src/rlh_pkg.sv
`default_nettype none

package rlh_pkg;

  localparam int LABEL_W = 16;
  localparam int INDEX_W = 12;
  localparam int OUT_W   = 32;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUMP,
    ST_RESP
  } state_t;

  localparam logic CFG_MIN_LABEL = 1'b0;
  localparam logic CFG_MAX_LABEL = 1'b1;

endpackage

`default_nettype wire

### src/rlh_bin_ram.sv
`default_nettype none

module rlh_bin_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### src/ranged_label_histogram_unit.sv
`default_nettype none

// Label histogram with a configurable range.
// Input stream s_*: one item per transfer (op, label, bin_index). op count sorts
// the label into background (zero), a bin (min_label..max_label, offset from
// min_label, up to BIN_COUNT), above or below; op read returns one bin and the
// three side counters on m_*; op clear zeroes everything. All counts saturate.
// Config port: cfg_we with cfg_index 0 (min_label) or 1 (max_label); write only
// while the block is idle.
// Timing: a count into a bin reads in ST_IDLE, then writes back in ST_BUMP
// through the single-port bin memory; a count into a side counter or an unused
// op needs only ST_IDLE; a read goes on to ST_RESP, which loads its result into
// the output register once that is free; a clear sweeps every bin in ST_CLEAR.
// After reset the block sweeps every entry of the bin memory with
// s_tready low. If the receiver stalls, the result waits in the output
// register and count items keep flowing; a second read waits until the first
// result has been taken.
module ranged_label_histogram_unit #(
  parameter int BIN_COUNT   = 4096,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // op [1:0], label [17:2], bin_index [29:18], zero [31:30]
  input  wire logic [31:0]  s_tdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // bin_count [31:0], background_count [63:32], above_count [95:64],
  // below_count [127:96]
  output logic      [127:0] m_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int AW = $clog2(BIN_COUNT);
  localparam int CW = COUNT_WIDTH;
  localparam logic [AW-1:0] LastAddr = AW'(BIN_COUNT - 1);
  localparam logic [16:0] BinLimit = 17'(BIN_COUNT);

  rlh_pkg::state_t state, state_next;

  logic signed [15:0] min_label, max_label;
  logic [CW-1:0] zero_tally, high_tally, low_tally;
  logic [AW-1:0] clr_addr, addr;
  logic          read_ok;
  logic [rlh_pkg::OUT_W-1:0] out_bin, out_zero, out_high, out_low;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [CW-1:0] mem_wdata, rdata, bin_bumped, bin_value;

  logic               accept, load_out;
  rlh_pkg::op_t       op;
  logic signed [15:0] label;
  logic [11:0]        bin_index;
  logic signed [16:0] off;
  logic               in_rng, to_bin, to_zero, to_high, to_low, idx_ok;

  assign op        = rlh_pkg::op_t'(s_tdata[1:0]);
  assign label     = s_tdata[17:2];
  assign bin_index = s_tdata[29:18];

  // sort the label
  assign off     = {label[15], label} - {min_label[15], min_label};
  assign in_rng  = (label >= min_label) && (label <= max_label);
  assign to_zero = (label == 16'sd0);
  assign to_bin  = !to_zero && in_rng && (unsigned'(off) < BinLimit);
  assign to_high = !to_zero && !to_bin && (in_rng || (label > max_label));
  assign to_low  = !to_zero && !in_rng && !(label > max_label);
  assign idx_ok  = {5'd0, bin_index} < BinLimit;

  assign accept     = s_tvalid && s_tready;
  assign bin_bumped = (rdata == '1) ? rdata : rdata + CW'(1);
  assign bin_value  = read_ok ? rdata : '0;

  rlh_bin_ram #(
    .DEPTH(BIN_COUNT),
    .WIDTH(CW)
  ) u_bins (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = addr;
    mem_wdata  = bin_bumped;
    load_out   = 1'b0;
    case (state)
      rlh_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
        if (clr_addr == LastAddr) begin
          state_next = rlh_pkg::ST_IDLE;
        end
      end
      rlh_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (op)
            rlh_pkg::OP_COUNT: begin
              if (to_bin) begin
                mem_addr   = off[AW-1:0];
                state_next = rlh_pkg::ST_BUMP;
              end
            end
            rlh_pkg::OP_READ: begin
              mem_addr   = AW'(bin_index);
              state_next = rlh_pkg::ST_RESP;
            end
            rlh_pkg::OP_CLEAR: begin
              state_next = rlh_pkg::ST_CLEAR;
            end
            default: begin
              state_next = rlh_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rlh_pkg::ST_BUMP: begin
        mem_we     = 1'b1;
        state_next = rlh_pkg::ST_IDLE;
      end
      rlh_pkg::ST_RESP: begin
        // keep reading the same entry while the output register is full
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = rlh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rlh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rlh_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == rlh_pkg::ST_CLEAR) begin
        clr_addr <= (clr_addr == LastAddr) ? '0 : clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr    <= mem_addr;
      read_ok <= idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_label <= 16'sd1;
      max_label <= 16'sd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        rlh_pkg::CFG_MIN_LABEL: min_label <= cfg_data;
        rlh_pkg::CFG_MAX_LABEL: max_label <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tally <= '0;
      high_tally <= '0;
      low_tally  <= '0;
    end else if (accept && op == rlh_pkg::OP_CLEAR) begin
      zero_tally <= '0;
      high_tally <= '0;
      low_tally  <= '0;
    end else if (accept && op == rlh_pkg::OP_COUNT) begin
      if (to_zero && zero_tally != '1) begin
        zero_tally <= zero_tally + CW'(1);
      end
      if (to_high && high_tally != '1) begin
        high_tally <= high_tally + CW'(1);
      end
      if (to_low && low_tally != '1) begin
        low_tally <= low_tally + CW'(1);
      end
    end
  end

  // counts wider than the output give their low bits
  logic [CW+31:0] ext_bin, ext_zero, ext_high, ext_low;
  assign ext_bin  = {32'd0, bin_value};
  assign ext_zero = {32'd0, zero_tally};
  assign ext_high = {32'd0, high_tally};
  assign ext_low  = {32'd0, low_tally};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bin  <= ext_bin[31:0];
      out_zero <= ext_zero[31:0];
      out_high <= ext_high[31:0];
      out_low  <= ext_low[31:0];
    end
  end

  assign m_tdata = {out_low, out_high, out_zero, out_bin};

endmodule

`default_nettype wire

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINS = 4096;
  localparam int SETTLE_CYCLES = 5000;   // covers a clear sweep still running
  localparam int IDLE_LIMIT = 30000;
  localparam int LONG_HOLD = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [15:0]  label;
    logic [11:0]         bin_index;
  } hist_item_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] background_count;
    logic [31:0] above_count;
    logic [31:0] below_count;
  } tally_snap_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [31:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ranged_label_histogram_unit #(
    .BIN_COUNT(BINS),
    .COUNT_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // histogram state mirrored by the testbench
  logic [31:0] bin_tally [BINS];
  logic [31:0] bg_tally;
  logic [31:0] above_tally;
  logic [31:0] below_tally;
  logic signed [15:0] lo_lim = 16'sd1;
  logic signed [15:0] hi_lim = 16'sd4096;

  hist_item_t item_q [$];
  tally_snap_t read_q [$];
  int errors = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  task automatic clear_tallies();
    for (int i = 0; i < BINS; i++) bin_tally[i] = '0;
    bg_tally = '0;
    above_tally = '0;
    below_tally = '0;
  endtask

  task automatic hist_apply(hist_item_t it);
    int off;
    tally_snap_t snap;
    case (it.op)
      rlh_pkg::OP_COUNT: begin
        if (it.label == 16'sd0) begin
          bg_tally = sat_inc(bg_tally);
        end else if (it.label >= lo_lim && it.label <= hi_lim) begin
          off = int'(it.label) - int'(lo_lim);
          // in range but past the last bin goes to the above counter
          if (off < BINS) bin_tally[off] = sat_inc(bin_tally[off]);
          else above_tally = sat_inc(above_tally);
        end else if (it.label > hi_lim) begin
          above_tally = sat_inc(above_tally);
        end else begin
          below_tally = sat_inc(below_tally);
        end
      end
      rlh_pkg::OP_READ: begin
        snap.bin_count = (int'(it.bin_index) < BINS) ? bin_tally[it.bin_index] : '0;
        snap.background_count = bg_tally;
        snap.above_count = above_tally;
        snap.below_count = below_tally;
        read_q.push_back(snap);
      end
      rlh_pkg::OP_CLEAR: clear_tallies();
      default: ;
    endcase
  endtask

  initial clear_tallies();

  // driver: bursts of random length with random gaps
  hist_item_t cur_item;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) hist_apply(cur_item);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
          cur_item = item_q.pop_front();
          s_tdata <= {2'b00, cur_item.bin_index, cur_item.label, cur_item.op};
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern follows rx_cyc[8:6], plus one long hold-off
  int rx_cyc = 0;
  int hold_left = 0;
  bit long_hold_go = 1'b0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cyc++;
      if (long_hold_go && !long_hold_done) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_cyc[8:6])
          3'd2: m_tready <= ($urandom_range(0, 1) != 0);
          3'd3: m_tready <= ($urandom_range(0, 3) == 0);
          3'd4: m_tready <= (rx_cyc[2:0] != 3'd0);
          3'd5: m_tready <= ($urandom_range(0, 4) != 0);
          3'd6: m_tready <= ($urandom_range(0, 7) == 0);
          default: m_tready <= 1'b1;
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    tally_snap_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (read_q.size() == 0) begin
        $error("result with no read outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = read_q.pop_front();
        check_field("bin_count", want.bin_count, m_tdata[31:0]);
        check_field("background_count", want.background_count, m_tdata[63:32]);
        check_field("above_count", want.above_count, m_tdata[95:64]);
        check_field("below_count", want.below_count, m_tdata[127:96]);
      end
    end
  end

  // watchdog on cycles with no transfer
  int idle_cyc = 0;

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic hist_item_t mk(logic [1:0] op, int lab, int idx);
    hist_item_t it;
    it.op = op;
    it.label = 16'(lab);
    it.bin_index = 12'(idx);
    return it;
  endfunction

  function automatic int rand_label();
    int lo;
    int hi;
    int pick;
    lo = int'(lo_lim);
    hi = int'(hi_lim);
    pick = $urandom_range(0, 99);
    if (pick < 10) return 0;
    // narrow window so bins get repeated hits
    if (pick < 50 && lo <= hi) return lo + $urandom_range(0, (hi - lo > 63) ? 63 : hi - lo);
    if (pick < 65) begin
      case ($urandom_range(0, 5))
        0: return lo - 1;
        1: return lo;
        2: return hi;
        3: return hi + 1;
        4: return lo + BINS - 1;
        default: return lo + BINS;
      endcase
    end
    return $urandom_range(0, 65535);
  endfunction

  function automatic hist_item_t rand_item();
    int r;
    int idx;
    logic [1:0] op;
    r = $urandom_range(0, 999);
    if (r < 4) op = rlh_pkg::OP_CLEAR;
    else if (r < 30) op = OP_UNUSED;
    else if (r < 280) op = rlh_pkg::OP_READ;
    else op = rlh_pkg::OP_COUNT;
    idx = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
    return mk(op, (op == rlh_pkg::OP_COUNT) ? rand_label() : $urandom_range(0, 65535), idx);
  endfunction

  task automatic add_random(int n);
    repeat (n) item_q.push_back(rand_item());
  endtask

  task automatic wait_drained(int settle);
    do @(posedge clk); while (item_q.size() != 0 || s_tvalid || read_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rlh_pkg::CFG_MIN_LABEL) lo_lim = value;
    else hi_lim = value;
  endtask

  task automatic set_range(int lo, int hi);
    write_reg(rlh_pkg::CFG_MIN_LABEL, 16'(lo));
    write_reg(rlh_pkg::CFG_MAX_LABEL, 16'(hi));
  endtask

  initial begin
    int lo;
    int hi;
    // reset range 1..4096: edges, repeats, side counters, unused op, clear
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 0, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 1, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 1, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 1, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 4096, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 4097, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 32767, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, -1, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, -32768, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 2, 0));
    item_q.push_back(mk(OP_UNUSED, 1, 0));
    item_q.push_back(mk(rlh_pkg::OP_READ, 0, 0));
    item_q.push_back(mk(rlh_pkg::OP_READ, 0, 4095));
    item_q.push_back(mk(rlh_pkg::OP_READ, 0, 1));
    item_q.push_back(mk(rlh_pkg::OP_CLEAR, 0, 0));
    item_q.push_back(mk(rlh_pkg::OP_READ, 0, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 0, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 5, 0));
    item_q.push_back(mk(rlh_pkg::OP_READ, 0, 4));
    add_random(200);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait_drained(SETTLE_CYCLES);

    // full range: labels past the last bin count as above
    set_range(-32768, 32767);
    item_q.push_back(mk(rlh_pkg::OP_COUNT, -32768, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, -28673, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, -28672, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 5000, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 0, 0));
    item_q.push_back(mk(rlh_pkg::OP_READ, 0, 0));
    item_q.push_back(mk(rlh_pkg::OP_READ, 0, 4095));
    long_hold_go = 1'b1;
    add_random(200);
    wait_drained(SETTLE_CYCLES);

    // min above max: nothing is in range
    set_range(100, -100);
    item_q.push_back(mk(rlh_pkg::OP_COUNT, 50, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, -200, 0));
    item_q.push_back(mk(rlh_pkg::OP_COUNT, -50, 0));
    item_q.push_back(mk(rlh_pkg::OP_READ, 0, 0));
    add_random(150);
    wait_drained(SETTLE_CYCLES);

    set_range(32767, 32767);
    add_random(100);
    wait_drained(SETTLE_CYCLES);

    set_range(-32768, -32768);
    add_random(100);
    wait_drained(SETTLE_CYCLES);

    set_range(-50, 50);
    add_random(200);
    wait_drained(SETTLE_CYCLES);

    lo = int'($urandom_range(0, 65535)) - 32768;
    hi = lo + int'($urandom_range(0, 8000));
    if (hi > 32767) hi = 32767;
    set_range(lo, hi);
    add_random(200);
    wait_drained(50);

    if (read_q.size() != 0) begin
      $error("%0d read results never arrived", read_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
